// ----- hw/rtl/pvrp_pkg.sv -----
// Shared types, register codes and address mapping for the video register port.
package pvrp_pkg;

    localparam int VIDEO_MEM_DEPTH = 16384;
    localparam int VADDR_W         = 14;

    typedef logic [VADDR_W-1:0] t_vaddr;

    // Processor-visible register numbers
    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDRESS = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Configuration register indexes (word address)
    localparam logic CFG_MIRROR_VERTICAL = 1'b0;
    localparam logic CFG_FOUR_SCREEN     = 1'b1;

    localparam t_vaddr PAL_BASE     = 14'h3F00;
    localparam t_vaddr NT_MIRROR_LO = 14'h3000;
    localparam t_vaddr NT_OFFSET    = 14'h1000;
    localparam t_vaddr NT_2400      = 14'h2400;
    localparam t_vaddr NT_2800      = 14'h2800;
    localparam t_vaddr NT_2C00      = 14'h2C00;
    localparam t_vaddr VERT_STEP    = 14'h0800;
    localparam t_vaddr HORZ_STEP    = 14'h0400;
    localparam t_vaddr STEP_ROW     = 14'd32;
    localparam t_vaddr STEP_ONE     = 14'd1;

    typedef struct packed {
        logic mirror_vertical;
        logic four_screen;
    } t_cfg;

    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        t_vaddr     addr;
        logic [7:0] wdata;
    } t_vram_req;

    typedef struct packed {
        logic       wr_en;
        logic       wr_dual;
        logic [4:0] idx;
        logic [7:0] wdata;
    } t_pal_req;

    // Map a wrapped address below the palette area to its video memory entry.
    function automatic t_vaddr map_addr(t_vaddr a, t_cfg cfg);
        t_vaddr m;
        m = a;
        if (a >= NT_MIRROR_LO && a < PAL_BASE) begin
            m = a - NT_OFFSET;
        end
        if (!cfg.four_screen && m < PAL_BASE) begin
            if (cfg.mirror_vertical) begin
                if (m >= NT_2800) begin
                    m = m - VERT_STEP;
                end
            end else if ((m >= NT_2400 && m < NT_2800) || m >= NT_2C00) begin
                m = m - HORZ_STEP;
            end
        end
        return m;
    endfunction

endpackage

// ----- hw/rtl/pvrp_cfg.sv -----
// APB configuration registers: nametable mirroring mode.
module pvrp_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic [2:0]       i_paddr,
    input  logic [31:0]      i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready,
    output pvrp_pkg::t_cfg   o_cfg
);
    import pvrp_pkg::*;

    logic r_mirror_vertical;
    logic r_four_screen;
    logic wr_go;

    assign wr_go    = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror_vertical <= 1'b0;
            r_four_screen     <= 1'b0;
        end else if (wr_go) begin
            unique case (i_paddr[2])
                CFG_MIRROR_VERTICAL: r_mirror_vertical <= i_pwdata[0];
                CFG_FOUR_SCREEN:     r_four_screen     <= i_pwdata[0];
                default:             r_four_screen     <= r_four_screen;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        unique case (i_paddr[2])
            CFG_MIRROR_VERTICAL: o_prdata[0] = r_mirror_vertical;
            CFG_FOUR_SCREEN:     o_prdata[0] = r_four_screen;
            default:             o_prdata    = '0;
        endcase
    end

    assign o_cfg.mirror_vertical = r_mirror_vertical;
    assign o_cfg.four_screen     = r_four_screen;

endmodule

// ----- hw/rtl/pvrp_pal.sv -----
// Palette store: 32 entries, dual write for entries mirrored at multiples of four.
module pvrp_pal (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pvrp_pkg::t_pal_req i_req,
    input  logic [4:0]         i_rd_idx,
    output logic [7:0]         o_rdata
);
    import pvrp_pkg::*;

    localparam int PAL_ENTRIES = 32;

    logic [7:0] r_pal [PAL_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAL_ENTRIES; i++) begin
                r_pal[i] <= '0;
            end
        end else if (i_req.wr_en) begin
            r_pal[i_req.idx] <= i_req.wdata;
            // backdrop entries are shared between the two halves
            if (i_req.wr_dual) begin
                r_pal[i_req.idx ^ 5'h10] <= i_req.wdata;
            end
        end
    end

    assign o_rdata = r_pal[i_rd_idx];

endmodule

// ----- hw/rtl/pvrp_vram.sv -----
// Video memory: one write and one registered read port, swept to zero after reset.
module pvrp_vram #(
    parameter int VIDEO_MEM_DEPTH = pvrp_pkg::VIDEO_MEM_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pvrp_pkg::t_vram_req i_req,
    output logic [7:0]          o_rdata,
    output logic                o_busy
);
    import pvrp_pkg::*;

    localparam int AW = $clog2(VIDEO_MEM_DEPTH);

    logic [7:0]    r_mem [VIDEO_MEM_DEPTH];
    logic [7:0]    r_rdata;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] req_addr;

    assign req_addr = AW'(i_req.addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(VIDEO_MEM_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[req_addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[req_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

// ----- hw/rtl/ppu_vram_register_port_top.sv -----
// Result: o_result_valid strobes in the cycle after its request is taken.
// Throughput: one request per cycle while busy is low; the single video memory port serves one access each.
// Reset: synchronous, active low; afterwards busy stays high while
// the video memory is swept to zero one entry per cycle (configuration still accepted).
// Results cannot be stalled by the receiver.
module ppu_vram_register_port_top #(
    parameter int VIDEO_MEM_DEPTH = pvrp_pkg::VIDEO_MEM_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [2:0]  i_reg_index,
    input  logic [7:0]  i_write_data,
    output logic        o_result_valid,
    output logic [7:0]  o_read_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pvrp_pkg::*;

    t_cfg      cfg;
    t_vram_req vram_req;
    t_pal_req  pal_req;
    logic [7:0] vram_rdata;
    logic [7:0] pal_rdata;
    logic       vram_busy;

    logic        r_valid;
    logic [7:0]  r_read_data;
    t_vaddr      r_cur_addr;
    logic [14:0] r_pending;
    logic        r_toggle;
    logic        r_incr_32;
    logic [7:0]  r_prefetch;
    logic        r_pf_from_mem;

    t_vaddr      n_cur_addr;
    logic [14:0] n_pending;
    logic        n_toggle;
    logic        n_incr_32;
    logic        n_pf_from_mem;
    logic [7:0]  n_read_data;

    logic       acc;
    logic       in_pal;
    t_vaddr     cur_map;
    t_vaddr     rd_map;
    t_vaddr     step_addr;
    logic [7:0] eff_pf;

    pvrp_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    pvrp_vram #(
        .VIDEO_MEM_DEPTH (VIDEO_MEM_DEPTH)
    ) u_vram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (vram_req),
        .o_rdata (vram_rdata),
        .o_busy  (vram_busy)
    );

    pvrp_pal u_pal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (pal_req),
        .i_rd_idx (r_cur_addr[4:0]),
        .o_rdata  (pal_rdata)
    );

    assign busy = vram_busy;
    assign acc  = start && !vram_busy;

    assign in_pal    = r_cur_addr >= PAL_BASE;
    assign cur_map   = map_addr(r_cur_addr, cfg);
    // palette reads refill the buffer from the nametable byte underneath
    assign rd_map    = in_pal ? map_addr(r_cur_addr - NT_OFFSET, cfg) : cur_map;
    assign step_addr = r_cur_addr + (r_incr_32 ? STEP_ROW : STEP_ONE);
    // buffer refill lands in the memory read register on the next cycle
    assign eff_pf    = r_pf_from_mem ? vram_rdata : r_prefetch;

    always_comb begin
        n_cur_addr     = r_cur_addr;
        n_pending      = r_pending;
        n_toggle       = r_toggle;
        n_incr_32      = r_incr_32;
        n_pf_from_mem  = 1'b0;
        n_read_data    = '0;
        vram_req.rd_en = 1'b0;
        vram_req.wr_en = 1'b0;
        vram_req.addr  = cur_map;
        vram_req.wdata = i_write_data;
        pal_req.wr_en  = 1'b0;
        pal_req.wr_dual = (r_cur_addr[1:0] == 2'b00);
        pal_req.idx    = r_cur_addr[4:0];
        pal_req.wdata  = i_write_data;
        if (acc) begin
            if (i_req_type == REQ_WRITE) begin
                unique case (i_reg_index)
                    REG_CONTROL: begin
                        n_incr_32 = i_write_data[2];
                        n_pending = {r_pending[14:12], i_write_data[1:0], r_pending[9:0]};
                    end
                    REG_SCROLL: begin
                        if (!r_toggle) begin
                            n_pending = {r_pending[14:5], i_write_data[7:3]};
                        end else begin
                            n_pending = {i_write_data[2:0], r_pending[11:10],
                                         i_write_data[7:3], r_pending[4:0]};
                        end
                        n_toggle = !r_toggle;
                    end
                    REG_ADDRESS: begin
                        if (!r_toggle) begin
                            n_pending = {1'b0, i_write_data[5:0], r_pending[7:0]};
                        end else begin
                            n_pending  = {r_pending[14:8], i_write_data};
                            n_cur_addr = {r_pending[13:8], i_write_data};
                        end
                        n_toggle = !r_toggle;
                    end
                    REG_DATA: begin
                        pal_req.wr_en  = in_pal;
                        vram_req.wr_en = !in_pal;
                        n_cur_addr     = step_addr;
                    end
                    default: begin
                        n_pending = r_pending;
                    end
                endcase
            end else if (i_reg_index == REG_DATA) begin
                vram_req.rd_en = 1'b1;
                vram_req.addr  = rd_map;
                n_pf_from_mem  = 1'b1;
                n_read_data    = in_pal ? pal_rdata : eff_pf;
                n_cur_addr     = step_addr;
                n_toggle       = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_cur_addr    <= '0;
            r_pending     <= '0;
            r_toggle      <= 1'b0;
            r_incr_32     <= 1'b0;
            r_prefetch    <= '0;
            r_pf_from_mem <= 1'b0;
        end else begin
            r_valid       <= acc;
            r_cur_addr    <= n_cur_addr;
            r_pending     <= n_pending;
            r_toggle      <= n_toggle;
            r_incr_32     <= n_incr_32;
            r_prefetch    <= eff_pf;
            r_pf_from_mem <= n_pf_from_mem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_data <= n_read_data;
    end

    assign o_result_valid = r_valid;
    assign o_read_data    = r_read_data;

`ifndef SYNTHESIS
    a_result_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_result_valid)
        else $error("request taken without a result on the next cycle");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_result_valid)
        else $error("result strobe without a request");

    a_nonzero_only_on_data_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !(i_req_type == REQ_READ && i_reg_index == REG_DATA))
        |=> (o_read_data == 8'h00))
        else $error("nonzero read data for a request other than a data read");

    a_no_prefetch_hold_without_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pf_from_mem |-> $past(vram_req.rd_en))
        else $error("read buffer forwarded without a memory read");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for the video register port: processor bus traffic, mirroring modes.
module tb;
    import pvrp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS_PER_MODE = 410;

    typedef struct {
        logic       kind;
        logic [2:0] reg_no;
        logic [7:0] data;
    } t_bus_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_req_type = 1'b0;
    logic [2:0]  i_reg_index = 3'd0;
    logic [7:0]  i_write_data = 8'd0;
    logic        o_result_valid;
    logic [7:0]  o_read_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted state of the port
    bit [7:0]  vmem [VIDEO_MEM_DEPTH];
    bit [15:0] vram_addr;
    bit [15:0] tmp_addr;
    bit        write_toggle;
    bit [7:0]  read_buf;
    bit [7:0]  ctrl_byte;
    bit        mirror_v;
    bit        four_scr;

    t_bus_req   bus_reqs [$];
    logic [7:0] expected_rdata [$];

    bit       took_req;
    bit       gen_toggle;
    int       gap_left;
    int       steady_left;
    int       roll;
    t_bus_req next_req;
    logic [7:0] want;
    int       errors;
    int       cycle_count;
    int       queued_items;
    int       reqs_taken;
    int       data_reads;
    int       data_writes;
    int       settings_done;
    logic [1:0] modes [4] = '{2'b01, 2'b10, 2'b11, 2'b00};  // {four_screen, vertical}

    ppu_vram_register_port_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_reg_index    (i_reg_index),
        .i_write_data   (i_write_data),
        .o_result_valid (o_result_valid),
        .o_read_data    (o_read_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        errors++;
        if (errors <= 40) begin
            $display("mismatch in %s: got %0h, want %0h (cycle %0d)",
                     what, got, exp_val, cycle_count);
        end
    endtask

    // Wrap to 14 bits, fold 0x3000 and palette areas, then nametable mirroring.
    function automatic logic [13:0] vram_slot(logic [15:0] addr);
        logic [13:0] a;
        a = addr[13:0];
        if (a >= 14'h3000 && a < 14'h3F00) begin
            a = a - 14'h1000;
        end else if (a >= 14'h3F00) begin
            a = 14'h3F00 | {9'd0, a[4:0]};
        end
        if (!four_scr) begin
            if (mirror_v) begin
                if (a >= 14'h2800 && a < 14'h3F00) begin
                    a = a - 14'h0800;
                end
            end else if ((a >= 14'h2400 && a < 14'h2800) ||
                         (a >= 14'h2C00 && a < 14'h3F00)) begin
                a = a - 14'h0400;
            end
        end
        return a;
    endfunction

    function automatic void step_vram_addr();
        vram_addr = vram_addr + (ctrl_byte[2] ? 16'd32 : 16'd1);
    endfunction

    function automatic logic [7:0] predict_port_read(logic kind, logic [2:0] reg_no,
                                                     logic [7:0] d);
        logic [15:0] t;
        logic [13:0] slot;
        logic [13:0] w;
        logic [7:0]  rd;
        rd = 8'h00;
        t = tmp_addr;
        if (kind == REQ_WRITE) begin
            case (reg_no)
                REG_CONTROL: begin
                    ctrl_byte = d;
                    t[11:10] = d[1:0];
                end
                REG_SCROLL: begin
                    if (!write_toggle) begin
                        t[4:0] = d[7:3];
                    end else begin
                        t = t & 16'h0C1F;
                        t[9:5] = d[7:3];
                        t[14:12] = d[2:0];
                    end
                    write_toggle = !write_toggle;
                end
                REG_ADDRESS: begin
                    if (!write_toggle) begin
                        t = {2'b00, d[5:0], t[7:0]};
                    end else begin
                        t = {t[15:8], d};
                        vram_addr = t;
                    end
                    write_toggle = !write_toggle;
                end
                REG_DATA: begin
                    slot = vram_slot(vram_addr);
                    vmem[slot] = d;
                    // palette entries on a multiple of four share storage with their mirror
                    if (slot >= 14'h3F00 && slot[1:0] == 2'b00) begin
                        vmem[slot < 14'h3F10 ? slot + 14'h10 : slot - 14'h10] = d;
                    end
                    step_vram_addr();
                end
                default: ;
            endcase
            tmp_addr = t;
        end else if (reg_no == REG_DATA) begin
            w = vram_addr[13:0];
            if (w >= 14'h3F00) begin
                rd = vmem[vram_slot({2'b00, w})];
                read_buf = vmem[vram_slot({2'b00, w - 14'h1000})];
            end else begin
                rd = read_buf;
                read_buf = vmem[vram_slot({2'b00, w})];
            end
            step_vram_addr();
            write_toggle = 1'b0;
        end
        return rd;
    endfunction

    task automatic queue_req(logic kind, logic [2:0] reg_no, logic [7:0] d);
        t_bus_req r;
        r.kind = kind;
        r.reg_no = reg_no;
        r.data = d;
        bus_reqs.push_back(r);
        if (kind == REQ_WRITE && (reg_no == REG_SCROLL || reg_no == REG_ADDRESS)) begin
            gen_toggle = !gen_toggle;
        end else if (kind == REQ_READ && reg_no == REG_DATA) begin
            gen_toggle = 1'b0;
        end
        if (reg_no == REG_CONTROL || reg_no >= REG_SCROLL) begin
            queued_items++;
        end
    endtask

    task automatic queue_set_address(logic [13:0] a);
        logic [7:0] r8;
        r8 = 8'($urandom);
        if (gen_toggle) begin
            queue_req(REQ_WRITE, REG_ADDRESS, r8);
        end
        r8 = 8'($urandom);
        queue_req(REQ_WRITE, REG_ADDRESS, {r8[7:6], a[13:8]});
        queue_req(REQ_WRITE, REG_ADDRESS, a[7:0]);
    endtask

    task automatic queue_random_traffic(int target);
        int goal;
        int pick;
        int n;
        int i;
        logic [13:0] a;
        logic [7:0]  r8;
        goal = queued_items + target;
        while (queued_items < goal) begin
            pick = $urandom_range(0, 99);
            n = $urandom_range(1, 10);
            case ($urandom_range(0, 9))
                0, 1:       a = 14'($urandom_range(0, 16'h3FFF));
                2, 3, 4, 5: a = 14'($urandom_range(16'h2000, 16'h3EFF));
                6, 7, 8:    a = 14'($urandom_range(16'h3F00, 16'h3FFF));
                default:    a = 14'($urandom_range(16'h3EE0, 16'h3F20));
            endcase
            if (pick < 55) begin
                queue_set_address(a);
                for (i = 0; i < n; i++) begin
                    r8 = 8'($urandom);
                    queue_req(($urandom_range(0, 1) == 1) ? REQ_WRITE : REQ_READ, REG_DATA, r8);
                end
            end else if (pick < 70) begin
                // fill a run, then read it back through the prefetch buffer
                queue_set_address(a);
                for (i = 0; i < n; i++) begin
                    r8 = 8'($urandom);
                    queue_req(REQ_WRITE, REG_DATA, r8);
                end
                queue_set_address(a);
                for (i = 0; i <= n; i++) begin
                    r8 = 8'($urandom);
                    queue_req(REQ_READ, REG_DATA, r8);
                end
            end else if (pick < 80) begin
                r8 = 8'($urandom);
                r8[2] = ($urandom_range(0, 2) == 0);
                queue_req(REQ_WRITE, REG_CONTROL, r8);
            end else if (pick < 88) begin
                for (i = 0; i < $urandom_range(1, 2); i++) begin
                    r8 = 8'($urandom);
                    queue_req(REQ_WRITE, REG_SCROLL, r8);
                end
            end else begin
                for (i = 0; i < $urandom_range(1, 3); i++) begin
                    r8 = 8'($urandom);
                    queue_req(($urandom_range(0, 1) == 1) ? REQ_WRITE : REQ_READ,
                              3'($urandom_range(0, 7)), r8);
                end
            end
        end
    endtask

    task automatic apb_cycle(logic wr, logic idx, logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_mirroring(logic vert, logic four);
        logic [31:0] w;
        logic [31:0] rb;
        w = $urandom;
        w[0] = vert;
        apb_cycle(1'b1, CFG_MIRROR_VERTICAL, w, rb);
        mirror_v = vert;
        w = $urandom;
        w[0] = four;
        apb_cycle(1'b1, CFG_FOUR_SCREEN, w, rb);
        four_scr = four;
        apb_cycle(1'b0, CFG_MIRROR_VERTICAL, 32'd0, rb);
        if (rb[0] !== vert) report_mismatch("mirror_vertical readback", rb, 32'(vert));
        apb_cycle(1'b0, CFG_FOUR_SCREEN, 32'd0, rb);
        if (rb[0] !== four) report_mismatch("four_screen readback", rb, 32'(four));
        settings_done++;
    endtask

    // Sampled at the rising edge; the result check at the same edge may pop before or
    // after this test, which can only hold the exit back, never end it early.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (bus_reqs.size() != 0 || start || expected_rdata.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // Request driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || took_req)) begin
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (bus_reqs.size() > 0) begin
                next_req = bus_reqs.pop_front();
                start <= 1'b1;
                i_req_type <= next_req.kind;
                i_reg_index <= next_req.reg_no;
                i_write_data <= next_req.data;
                if (steady_left > 0) begin
                    steady_left--;
                    gap_left = 0;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3) steady_left = $urandom_range(40, 200);
                    if (roll < 55) gap_left = 0;
                    else if (roll < 88) gap_left = $urandom_range(1, 3);
                    else if (roll < 98) gap_left = $urandom_range(4, 12);
                    else gap_left = $urandom_range(20, 60);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result checker and request predictor
    always @(posedge i_clk) begin
        took_req = 1'b0;
        if (i_rst_n) begin
            if (o_result_valid === 1'b1) begin
                if (expected_rdata.size() == 0) begin
                    report_mismatch("read_data with nothing outstanding", 32'(o_read_data),
                                    32'd0);
                end else begin
                    want = expected_rdata.pop_front();
                    if (o_read_data !== want) begin
                        report_mismatch("read_data", 32'(o_read_data), 32'(want));
                    end
                end
            end else if (o_result_valid !== 1'b0) begin
                report_mismatch("result strobe unknown", 32'(o_result_valid), 32'd0);
            end
            if (start && busy === 1'b0) begin
                took_req = 1'b1;
                expected_rdata.push_back(predict_port_read(i_req_type, i_reg_index,
                                                           i_write_data));
                reqs_taken++;
                if (i_reg_index == REG_DATA) begin
                    if (i_req_type == REQ_READ) data_reads++;
                    else data_writes++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d requests taken", cycle_count, reqs_taken);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // configuration is taken while the memory sweep still runs
        set_mirroring(1'b0, 1'b0);

        // directed: prefetch after reset, ignored registers, palette and its mirrors
        queue_req(REQ_READ, REG_DATA, 8'h00);
        queue_req(REQ_READ, 3'd3, 8'h00);
        queue_req(REQ_WRITE, 3'd2, 8'hFF);
        queue_req(REQ_WRITE, 3'd4, 8'hAA);
        queue_req(REQ_WRITE, REG_CONTROL, 8'h00);
        queue_set_address(14'h3F00);
        queue_req(REQ_WRITE, REG_DATA, 8'h3F);
        queue_req(REQ_WRITE, REG_DATA, 8'h15);
        queue_set_address(14'h3F10);
        queue_req(REQ_READ, REG_DATA, 8'h00);
        queue_req(REQ_WRITE, REG_ADDRESS, 8'hFF);
        queue_req(REQ_WRITE, REG_ADDRESS, 8'h1C);
        queue_req(REQ_WRITE, REG_DATA, 8'hFF);
        // step of 32 through a nametable, then buffered readback
        queue_req(REQ_WRITE, REG_CONTROL, 8'hFF);
        queue_set_address(14'h2C00);
        queue_req(REQ_WRITE, REG_DATA, 8'h80);
        queue_req(REQ_WRITE, REG_DATA, 8'h01);
        queue_set_address(14'h2C00);
        queue_req(REQ_READ, REG_DATA, 8'h00);
        queue_req(REQ_READ, REG_DATA, 8'h00);
        // scroll pair with fine-y, then a second address write keeps bit 14
        queue_req(REQ_WRITE, REG_SCROLL, 8'hFF);
        queue_req(REQ_WRITE, REG_SCROLL, 8'h07);
        queue_req(REQ_WRITE, REG_SCROLL, 8'hF8);
        queue_req(REQ_WRITE, REG_ADDRESS, 8'h0C);
        queue_req(REQ_READ, REG_DATA, 8'h00);
        queue_req(REQ_READ, REG_CONTROL, 8'h00);
        queue_req(REQ_READ, REG_SCROLL, 8'h00);
        queue_req(REQ_READ, REG_ADDRESS, 8'h00);
        wait_drained();

        for (int m = 0; m < 4; m++) begin
            set_mirroring(modes[m][0], modes[m][1]);
            queue_random_traffic(RANDOM_ITEMS_PER_MODE);
            wait_drained();
        end

        if (expected_rdata.size() != 0) begin
            report_mismatch("results still outstanding", 32'(expected_rdata.size()), 32'd0);
        end
        $display("covered %0d requests (%0d data reads, %0d data writes)",
                 reqs_taken, data_reads, data_writes);
        $display("over %0d mirroring setups", settings_done);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/pvrp_pkg.sv
hw/rtl/pvrp_cfg.sv
hw/rtl/pvrp_pal.sv
hw/rtl/pvrp_vram.sv
hw/rtl/ppu_vram_register_port_top.sv
tb/sv/tb.sv
